/* rtl/psk31vc_pkg.sv */
package psk31vc_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CHAR_W = 8;
  localparam int CODE_W = 16;
  localparam int COUNT_OUT_W = 6;
  localparam int ROM_DEPTH = 256;

  localparam logic [CHAR_W-1:0] TOGGLE_CHAR = 8'h01;

  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic SYM_KEEP = 1'b0;
  localparam logic SYM_REVERSE = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef code_t rom_t [ROM_DEPTH];

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic   full;
    logic   empty;
    count_t count;
  } queue_stat_t;

  // standard varicode, right justified
  localparam logic [9:0] BASE_CODE [128] = '{
    10'h2AB, 10'h2DB, 10'h2ED, 10'h377, 10'h2EB, 10'h35F, 10'h2EF, 10'h2FD,
    10'h2FF, 10'h0EF, 10'h01D, 10'h36F, 10'h2DD, 10'h01F, 10'h375, 10'h3AB,
    10'h2F7, 10'h2F5, 10'h3AD, 10'h3AF, 10'h35B, 10'h36B, 10'h36D, 10'h357,
    10'h37B, 10'h37D, 10'h3B7, 10'h355, 10'h35D, 10'h3BB, 10'h2FB, 10'h37F,
    10'h001, 10'h1FF, 10'h15F, 10'h1F5, 10'h1DB, 10'h2D5, 10'h2BB, 10'h17F,
    10'h0FB, 10'h0F7, 10'h16F, 10'h1DF, 10'h075, 10'h035, 10'h057, 10'h1AF,
    10'h0B7, 10'h0BD, 10'h0ED, 10'h0FF, 10'h177, 10'h15B, 10'h16B, 10'h1AD,
    10'h1AB, 10'h1B7, 10'h0F5, 10'h1BD, 10'h1ED, 10'h055, 10'h1D7, 10'h2AF,
    10'h2BD, 10'h07D, 10'h0EB, 10'h0AD, 10'h0B5, 10'h077, 10'h0DB, 10'h0FD,
    10'h155, 10'h07F, 10'h1FD, 10'h17D, 10'h0D7, 10'h0BB, 10'h0DD, 10'h0AB,
    10'h0D5, 10'h1DD, 10'h0AF, 10'h06F, 10'h06D, 10'h157, 10'h1B5, 10'h15D,
    10'h175, 10'h17B, 10'h2AD, 10'h1F7, 10'h1EF, 10'h1FB, 10'h2BF, 10'h16D,
    10'h2DF, 10'h00B, 10'h05F, 10'h02F, 10'h02D, 10'h003, 10'h03D, 10'h05B,
    10'h02B, 10'h00D, 10'h1EB, 10'h0BF, 10'h01B, 10'h03B, 10'h00F, 10'h007,
    10'h03F, 10'h1BF, 10'h015, 10'h017, 10'h005, 10'h037, 10'h07B, 10'h06B,
    10'h0DF, 10'h05D, 10'h1D5, 10'h2B7, 10'h1BB, 10'h2B5, 10'h2D7, 10'h3B5
  };

  function automatic int bit_len(input logic [9:0] v);
    int n;
    n = 0;
    for (int b = 0; b < 10; b++) begin
      if (v[b]) begin
        n = b + 1;
      end
    end
    return n;
  endfunction

  // left justified codewords, extended set in order of length then value
  function automatic rom_t build_rom();
    rom_t          rom;
    logic [1023:0] seen;
    int            idx;
    int            mask;
    int            z;
    int            n;
    rom = '{default: '0};
    seen = '0;
    for (int i = 0; i < 128; i++) begin
      seen[BASE_CODE[i]] = 1'b1;
      n = bit_len(BASE_CODE[i]);
      rom[i] = CODE_W'(32'(BASE_CODE[i]) << (CODE_W - n));
    end
    idx = 128;
    for (int len = 10; len <= 12; len++) begin
      mask = (1 << len) - 1;
      for (int v = 1 << (len - 1); v <= mask; v++) begin
        z = ~v & mask;
        if (idx < ROM_DEPTH && v[0] && (z & (z >> 1)) == 0 &&
            !(v < 1024 && seen[v[9:0]])) begin
          rom[idx] = CODE_W'(v << (CODE_W - len));
          idx++;
        end
      end
    end
    return rom;
  endfunction

  localparam rom_t VARICODE_ROM = build_rom();

endpackage

/* rtl/psk31vc_queue.sv */
module psk31vc_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  psk31vc_pkg::queue_ctrl_t  ctrl,
  input  psk31vc_pkg::char_t        wr_data,
  output psk31vc_pkg::char_t        head,
  output psk31vc_pkg::queue_stat_t  stat
);

  psk31vc_pkg::char_t  mem [psk31vc_pkg::QUEUE_DEPTH];
  psk31vc_pkg::ptr_t   wr_ptr;
  psk31vc_pkg::ptr_t   rd_ptr;
  psk31vc_pkg::ptr_t   rd_ptr_next;
  psk31vc_pkg::ptr_t   wr_ptr_next;
  psk31vc_pkg::count_t count;

  function automatic psk31vc_pkg::ptr_t ptr_inc(input psk31vc_pkg::ptr_t p);
    if (p == psk31vc_pkg::PTR_W'(psk31vc_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    rd_ptr_next = ctrl.pop ? ptr_inc(rd_ptr) : rd_ptr;
    wr_ptr_next = ctrl.push ? ptr_inc(wr_ptr) : wr_ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      if (ctrl.push && !ctrl.pop) begin
        count <= count + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - 1'b1;
      end
    end
  end

  // head is the registered read of the oldest entry, with write bypass into an empty queue
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= wr_data;
    end
    if (ctrl.push && wr_ptr == rd_ptr_next) begin
      head <= wr_data;
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

  always_comb begin
    stat.count = count;
    stat.empty = (count == '0);
    stat.full = (count == psk31vc_pkg::CNT_W'(psk31vc_pkg::QUEUE_DEPTH));
  end

endmodule

/* rtl/psk31_varicode_symbol_source_unit.sv */
// channel  signals                               direction
// in       in_valid, in_stall, func, char_in     item in, stall out
// out      out_valid, out_stall, symbol,         item out, stall in
//          enqueue_ok, queue_count
//
// one item per cycle sustained while the result is not stalled; each item passes
// through the input register and then leaves through the result register.
// the varicode lookup reads the registered queue head through a constant table.
// rst is synchronous and clears the queue, the shift register and owes a gap.
// a stalled result holds; the input register still takes one more item.
module psk31_varicode_symbol_source_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     func,
  input  logic [psk31vc_pkg::CHAR_W-1:0]           char_in,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     symbol,
  output logic                                     enqueue_ok,
  output logic [psk31vc_pkg::COUNT_OUT_W-1:0]      queue_count
);

  logic                     in_v;
  logic                     func_r;
  psk31vc_pkg::char_t       char_r;
  logic                     advance;

  psk31vc_pkg::code_t       code_shift;
  psk31vc_pkg::code_t       code_shift_next;
  logic                     pending_gap;
  logic                     pending_gap_next;

  psk31vc_pkg::queue_ctrl_t q_ctrl;
  psk31vc_pkg::queue_stat_t q_stat;
  psk31vc_pkg::char_t       q_head;

  logic                     push_c;
  logic                     pop_c;
  logic                     sym_c;
  logic                     ok_c;
  psk31vc_pkg::count_t      count_c;
  logic [psk31vc_pkg::CNT_W+psk31vc_pkg::COUNT_OUT_W-1:0] count_ext;

  assign advance = in_v && (!out_valid || !out_stall);
  assign in_stall = in_v && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r <= func;
      char_r <= char_in;
    end
  end

  always_comb begin
    push_c = 1'b0;
    pop_c = 1'b0;
    sym_c = psk31vc_pkg::SYM_KEEP;
    ok_c = 1'b0;
    code_shift_next = code_shift;
    pending_gap_next = pending_gap;
    if (func_r == psk31vc_pkg::FUNC_ENQUEUE) begin
      if (!q_stat.full) begin
        push_c = 1'b1;
        ok_c = 1'b1;
      end
    end else if (code_shift == '0) begin
      sym_c = psk31vc_pkg::SYM_REVERSE;
      if (pending_gap) begin
        pending_gap_next = 1'b0;
      end else if (!q_stat.empty) begin
        pop_c = 1'b1;
        if (q_head != psk31vc_pkg::TOGGLE_CHAR) begin
          code_shift_next = psk31vc_pkg::VARICODE_ROM[q_head];
        end
      end
    end else begin
      sym_c = code_shift[psk31vc_pkg::CODE_W-1] ? psk31vc_pkg::SYM_KEEP
                                                : psk31vc_pkg::SYM_REVERSE;
      code_shift_next = {code_shift[psk31vc_pkg::CODE_W-2:0], 1'b0};
      if (code_shift_next == '0) begin
        pending_gap_next = 1'b1;
      end
    end
    priority if (push_c) begin
      count_c = q_stat.count + 1'b1;
    end else if (pop_c) begin
      count_c = q_stat.count - 1'b1;
    end else begin
      count_c = q_stat.count;
    end
    count_ext = {{psk31vc_pkg::COUNT_OUT_W{1'b0}}, count_c};
  end

  always_comb begin
    q_ctrl.push = push_c && advance;
    q_ctrl.pop = pop_c && advance;
  end

  psk31vc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (q_ctrl),
    .wr_data (char_r),
    .head    (q_head),
    .stat    (q_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      code_shift <= '0;
      pending_gap <= 1'b1;
    end else if (advance) begin
      code_shift <= code_shift_next;
      pending_gap <= pending_gap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      symbol <= sym_c;
      enqueue_ok <= ok_c;
      queue_count <= count_ext[psk31vc_pkg::COUNT_OUT_W-1:0];
    end
  end

`ifndef SYNTH
  a_gap_only_between_codes: assert property (@(posedge clk) disable iff (rst)
    code_shift != '0 |-> !pending_gap)
    else $error("separator owed while codeword still shifting");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_ctrl.push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_ctrl.pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_free_output_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");
`endif

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                                sym;
    logic                                ok;
    logic [psk31vc_pkg::COUNT_OUT_W-1:0] cnt;
  } tx_result_t;

  typedef struct {
    logic               f;
    psk31vc_pkg::char_t ch;
    bit                 typed;
    tx_result_t         res;
  } stim_row_t;

  // standard varicode, right justified, top set bit sent first
  localparam logic [9:0] STD_CODE [128] = '{
    10'h2AB, 10'h2DB, 10'h2ED, 10'h377, 10'h2EB, 10'h35F, 10'h2EF, 10'h2FD,
    10'h2FF, 10'h0EF, 10'h01D, 10'h36F, 10'h2DD, 10'h01F, 10'h375, 10'h3AB,
    10'h2F7, 10'h2F5, 10'h3AD, 10'h3AF, 10'h35B, 10'h36B, 10'h36D, 10'h357,
    10'h37B, 10'h37D, 10'h3B7, 10'h355, 10'h35D, 10'h3BB, 10'h2FB, 10'h37F,
    10'h001, 10'h1FF, 10'h15F, 10'h1F5, 10'h1DB, 10'h2D5, 10'h2BB, 10'h17F,
    10'h0FB, 10'h0F7, 10'h16F, 10'h1DF, 10'h075, 10'h035, 10'h057, 10'h1AF,
    10'h0B7, 10'h0BD, 10'h0ED, 10'h0FF, 10'h177, 10'h15B, 10'h16B, 10'h1AD,
    10'h1AB, 10'h1B7, 10'h0F5, 10'h1BD, 10'h1ED, 10'h055, 10'h1D7, 10'h2AF,
    10'h2BD, 10'h07D, 10'h0EB, 10'h0AD, 10'h0B5, 10'h077, 10'h0DB, 10'h0FD,
    10'h155, 10'h07F, 10'h1FD, 10'h17D, 10'h0D7, 10'h0BB, 10'h0DD, 10'h0AB,
    10'h0D5, 10'h1DD, 10'h0AF, 10'h06F, 10'h06D, 10'h157, 10'h1B5, 10'h15D,
    10'h175, 10'h17B, 10'h2AD, 10'h1F7, 10'h1EF, 10'h1FB, 10'h2BF, 10'h16D,
    10'h2DF, 10'h00B, 10'h05F, 10'h02F, 10'h02D, 10'h003, 10'h03D, 10'h05B,
    10'h02B, 10'h00D, 10'h1EB, 10'h0BF, 10'h01B, 10'h03B, 10'h00F, 10'h007,
    10'h03F, 10'h1BF, 10'h015, 10'h017, 10'h005, 10'h037, 10'h07B, 10'h06B,
    10'h0DF, 10'h05D, 10'h1D5, 10'h2B7, 10'h1BB, 10'h2B5, 10'h2D7, 10'h3B5
  };

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic                                func;
  psk31vc_pkg::char_t                  char_in;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                symbol;
  logic                                enqueue_ok;
  logic [psk31vc_pkg::COUNT_OUT_W-1:0] queue_count;

  psk31vc_pkg::code_t codebook [psk31vc_pkg::ROM_DEPTH];
  psk31vc_pkg::code_t enc_shift;
  bit                 gap_owed;
  psk31vc_pkg::char_t char_fifo [$];
  tx_result_t         pending_results [$];
  int                 errors = 0;
  int                 n_items = 0;
  int                 n_results = 0;
  int                 n_refused = 0;
  int                 n_toggles = 0;
  int                 burst_left = 1;
  int unsigned        rx_cycle = 0;
  int                 rx_run = 0;

  stim_row_t dir_rows [25] = '{
    '{psk31vc_pkg::FUNC_TICK,    8'h00, 1'b1, '{psk31vc_pkg::SYM_REVERSE, 1'b0, 6'd0}},
    '{psk31vc_pkg::FUNC_TICK,    8'hFF, 1'b1, '{psk31vc_pkg::SYM_REVERSE, 1'b0, 6'd0}},
    '{psk31vc_pkg::FUNC_ENQUEUE, 8'h01, 1'b1, '{psk31vc_pkg::SYM_KEEP,    1'b1, 6'd1}},
    '{psk31vc_pkg::FUNC_TICK,    8'h5A, 1'b1, '{psk31vc_pkg::SYM_REVERSE, 1'b0, 6'd0}},
    '{psk31vc_pkg::FUNC_TICK,    8'hA5, 1'b1, '{psk31vc_pkg::SYM_REVERSE, 1'b0, 6'd0}},
    '{psk31vc_pkg::FUNC_ENQUEUE, 8'h20, 1'b1, '{psk31vc_pkg::SYM_KEEP,    1'b1, 6'd1}},
    '{psk31vc_pkg::FUNC_ENQUEUE, 8'h00, 1'b1, '{psk31vc_pkg::SYM_KEEP,    1'b1, 6'd2}},
    '{psk31vc_pkg::FUNC_ENQUEUE, 8'hFF, 1'b1, '{psk31vc_pkg::SYM_KEEP,    1'b1, 6'd3}},
    '{psk31vc_pkg::FUNC_ENQUEUE, 8'h80, 1'b1, '{psk31vc_pkg::SYM_KEEP,    1'b1, 6'd4}},
    '{psk31vc_pkg::FUNC_TICK,    8'h00, 1'b1, '{psk31vc_pkg::SYM_REVERSE, 1'b0, 6'd3}},
    '{psk31vc_pkg::FUNC_TICK,    8'hFF, 1'b1, '{psk31vc_pkg::SYM_KEEP,    1'b0, 6'd3}},
    '{psk31vc_pkg::FUNC_TICK,    8'h00, 1'b1, '{psk31vc_pkg::SYM_REVERSE, 1'b0, 6'd3}},
    '{psk31vc_pkg::FUNC_TICK,    8'hFF, 1'b1, '{psk31vc_pkg::SYM_REVERSE, 1'b0, 6'd2}},
    '{psk31vc_pkg::FUNC_TICK,    8'h00, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'h7F, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'h00, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'hFF, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'h00, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'hFF, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'h00, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'hFF, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'h00, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'hFF, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'h00, 1'b0, '0},
    '{psk31vc_pkg::FUNC_TICK,    8'hFF, 1'b0, '0}
  };

  psk31_varicode_symbol_source_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .char_in     (char_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .enqueue_ok  (enqueue_ok),
    .queue_count (queue_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void build_codebook();
    bit [4095:0] seen;
    int          idx;
    int          n;
    int          z;
    int          mask;
    seen = '0;
    for (int i = 0; i < 128; i++) begin
      seen[STD_CODE[i]] = 1'b1;
      n = 0;
      for (int b = 0; b < 10; b++) begin
        if (STD_CODE[i][b]) begin
          n = b + 1;
        end
      end
      codebook[i] = psk31vc_pkg::code_t'(32'(STD_CODE[i]) << (psk31vc_pkg::CODE_W - n));
    end
    for (int i = 128; i < psk31vc_pkg::ROM_DEPTH; i++) begin
      codebook[i] = '0;
    end
    // extended set: odd codewords with no two adjacent zeros, by length then value
    idx = 128;
    for (int len = 10; len <= 12; len++) begin
      mask = (1 << len) - 1;
      for (int v = 1 << (len - 1); v <= mask; v++) begin
        z = ~v & mask;
        if (idx < psk31vc_pkg::ROM_DEPTH && v[0] && (z & (z >> 1)) == 0 && !seen[v]) begin
          codebook[idx] = psk31vc_pkg::code_t'(v << (psk31vc_pkg::CODE_W - len));
          idx++;
        end
      end
    end
  endfunction

  function automatic tx_result_t predict_symbol(input logic f, input psk31vc_pkg::char_t c);
    tx_result_t         r;
    psk31vc_pkg::char_t head;
    r = '0;
    if (f == psk31vc_pkg::FUNC_ENQUEUE) begin
      if (char_fifo.size() < psk31vc_pkg::QUEUE_DEPTH) begin
        char_fifo.push_back(c);
        r.ok = 1'b1;
      end
    end else if (enc_shift == '0) begin
      r.sym = psk31vc_pkg::SYM_REVERSE;
      if (gap_owed) begin
        gap_owed = 1'b0;
      end else if (char_fifo.size() != 0) begin
        head = char_fifo.pop_front();
        if (head == psk31vc_pkg::TOGGLE_CHAR) begin
          n_toggles++;
        end else begin
          enc_shift = codebook[head];
        end
      end
    end else begin
      r.sym = enc_shift[psk31vc_pkg::CODE_W-1] ? psk31vc_pkg::SYM_KEEP
                                               : psk31vc_pkg::SYM_REVERSE;
      enc_shift = enc_shift << 1;
      if (enc_shift == '0) begin
        gap_owed = 1'b1;
      end
    end
    r.cnt = psk31vc_pkg::COUNT_OUT_W'(char_fifo.size());
    return r;
  endfunction

  task automatic send_item(input logic f, input psk31vc_pkg::char_t c, input bit typed,
                           input tx_result_t typed_res);
    tx_result_t r;
    int         gap;
    @(negedge clk);
    in_valid <= 1'b1;
    func     <= f;
    char_in  <= c;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    r = predict_symbol(f, c);
    if (typed) begin
      r = typed_res;
    end
    if (f == psk31vc_pkg::FUNC_ENQUEUE && !r.ok) begin
      n_refused++;
    end
    pending_results.push_back(r);
    n_items++;
    // bursts with random gaps, junk payload while idle
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        func     <= 1'($urandom_range(0, 1));
        char_in  <= psk31vc_pkg::char_t'($urandom_range(0, 255));
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 16);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 150) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ((rx_cycle % 5) < 2);
      default: begin
        if (rx_run == 0 && $urandom_range(0, 7) == 0) begin
          rx_run = $urandom_range(1, 6);
        end
        out_stall <= (rx_run != 0);
        if (rx_run != 0) begin
          rx_run--;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    tx_result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, symbol %0b enqueue_ok %0b queue_count %0d",
                 $time, symbol, enqueue_ok, queue_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (symbol !== want.sym) begin
          $display("%0t: symbol mismatch, expected %0b got %0b", $time, want.sym, symbol);
          errors++;
        end
        if (enqueue_ok !== want.ok) begin
          $display("%0t: enqueue_ok mismatch, expected %0b got %0b",
                   $time, want.ok, enqueue_ok);
          errors++;
        end
        if (queue_count !== want.cnt) begin
          $display("%0t: queue_count mismatch, expected %0d got %0d",
                   $time, want.cnt, queue_count);
          errors++;
        end
      end
    end
  end

  initial begin
    int                 n_rand;
    int                 phase;
    int                 pct;
    int                 phase_len;
    int                 wait_cnt;
    logic               f;
    psk31vc_pkg::char_t c;
    rst      = 1'b1;
    in_valid = 1'b0;
    func     = psk31vc_pkg::FUNC_ENQUEUE;
    char_in  = '0;
    build_codebook();
    enc_shift = '0;
    gap_owed  = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].f, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].res);
    end

    // phases of varying enqueue pressure; the first one fills the queue
    n_rand = 0;
    phase  = 0;
    while (n_rand < 1100) begin
      if (phase == 0) begin
        pct       = 100;
        phase_len = 40;
      end else begin
        case ($urandom_range(0, 3))
          0: pct = 95;
          1: pct = 60;
          2: pct = 30;
          default: pct = 5;
        endcase
        phase_len = $urandom_range(80, 300);
      end
      for (int k = 0; k < phase_len && n_rand < 1100; k++) begin
        f = ($urandom_range(1, 100) <= pct) ? psk31vc_pkg::FUNC_ENQUEUE
                                             : psk31vc_pkg::FUNC_TICK;
        case ($urandom_range(0, 15))
          0, 1: c = psk31vc_pkg::TOGGLE_CHAR;
          2: c = 8'h00;
          3: c = 8'hFF;
          default: c = psk31vc_pkg::char_t'($urandom_range(0, 255));
        endcase
        send_item(f, c, 1'b0, '0);
        n_rand++;
      end
      phase++;
    end

    // drain the queue and finish with idle reversals
    for (int k = 0; k < 550; k++) begin
      send_item(psk31vc_pkg::FUNC_TICK, psk31vc_pkg::char_t'($urandom_range(0, 255)),
                1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors += pending_results.size();
    end

    $display("%0d items sent, %0d results checked, %0d phases of random traffic",
             n_items, n_results, phase);
    $display("%0d enqueues refused on a full queue, %0d toggle bytes dequeued",
             n_refused, n_toggles);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/psk31vc_pkg.sv
rtl/psk31vc_queue.sv
rtl/psk31_varicode_symbol_source_unit.sv
verif/tb.sv
